// File: hdl/pcec_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcec_pkg: shared types and constants of the per-CPU event counter table
// Operation codes, field widths, configuration register indexes and the
// classified item that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package pcec_pkg;

    localparam int OPCODE_W   = 3;
    localparam int CPU_ID_W   = 8;
    localparam int INDEX_W    = 12;
    localparam int AMOUNT_W   = 64;

    // Wide enough for the largest supported CPU count (64 CPUs).
    localparam int CPU_SEL_W  = 6;

    // Wide enough to compare a 4-bit register against up to 256 events.
    localparam int EV_CMP_W   = 9;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_EVENT_INDEX  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_INDEX = 2'd1;

    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = 1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD      = 3'd0,
        OP_SETMAX   = 3'd1,
        OP_SYSCALL  = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_EVSUM    = 3'd4,
        OP_EVMAX    = 3'd5,
        OP_SCCOUNT  = 3'd6,
        OP_SCCYCLES = 3'd7
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [CPU_SEL_W-1:0] cpu;
        logic [INDEX_W-1:0]   index;
        logic [AMOUNT_W-1:0]  amount;
        logic                 idx_ok;
    } t_item;

endpackage

// File: hdl/pcec_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcec_front: input stage
// Accepts input transfers, maps invalid CPU ids to CPU 0 and checks the index
// against the range that the operation uses, then pushes the item to the queue.
// ----------------------------------------------------------------------------
module pcec_front #(
    parameter int NUM_CPUS      = 4,
    parameter int NUM_EVENTS    = 16,
    parameter int SYSCALL_SLOTS = 512
) (
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pcec_pkg::OPCODE_W-1:0] i_opcode,
    input  logic [pcec_pkg::CPU_ID_W-1:0] i_cpu_id,
    input  logic [pcec_pkg::INDEX_W-1:0]  i_index,
    input  logic [pcec_pkg::AMOUNT_W-1:0] i_amount,
    input  logic                          i_init_busy,
    output logic                          o_push_valid,
    input  logic                          i_push_ready,
    output pcec_pkg::t_item               o_push_item
);

    pcec_pkg::t_op op;
    logic          cpu_ok;
    logic          ev_ok;
    logic          sc_ok;

    assign op     = pcec_pkg::t_op'(i_opcode);
    assign cpu_ok = i_cpu_id < pcec_pkg::CPU_ID_W'(NUM_CPUS);
    assign ev_ok  = i_index < pcec_pkg::INDEX_W'(NUM_EVENTS);
    assign sc_ok  = {1'b0, i_index} < (pcec_pkg::INDEX_W + 1)'(SYSCALL_SLOTS);

    // Nothing is taken in while the memories are being cleared after reset.
    assign o_in_ready   = i_push_ready && !i_init_busy;
    assign o_push_valid = i_in_valid && !i_init_busy;

    always_comb begin
        o_push_item.op     = op;
        o_push_item.cpu    = cpu_ok ? pcec_pkg::CPU_SEL_W'(i_cpu_id) : '0;
        o_push_item.index  = i_index;
        o_push_item.amount = i_amount;
        unique case (op)
            pcec_pkg::OP_ADD,
            pcec_pkg::OP_SETMAX,
            pcec_pkg::OP_EVSUM,
            pcec_pkg::OP_EVMAX:   o_push_item.idx_ok = ev_ok;
            pcec_pkg::OP_SYSCALL,
            pcec_pkg::OP_SCCOUNT,
            pcec_pkg::OP_SCCYCLES: o_push_item.idx_ok = sc_ok;
            pcec_pkg::OP_CLEAR:   o_push_item.idx_ok = 1'b1;
            default:              o_push_item.idx_ok = 1'b0;
        endcase
    end

endmodule

// File: hdl/pcec_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcec_fifo: command queue
// A short queue of classified items between the input stage and the back end.
// ----------------------------------------------------------------------------
module pcec_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  pcec_pkg::t_item i_push_item,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output pcec_pkg::t_item o_pop_item
);

    pcec_pkg::t_item                 r_mem [0:pcec_pkg::Q_DEPTH-1];
    logic [pcec_pkg::Q_AW-1:0]       r_wptr;
    logic [pcec_pkg::Q_AW-1:0]       r_rptr;
    logic [pcec_pkg::Q_AW:0]         r_count;
    logic                            push;
    logic                            pop;

    assign o_push_ready = r_count != (pcec_pkg::Q_AW + 1)'(pcec_pkg::Q_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_item   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

endmodule

// File: hdl/pcec_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcec_back: execution engine
// Holds the counter memories and the configuration registers, carries out one
// item at a time as read-modify-write steps, CPU walks or a clearing sweep,
// and drives the result register.
// ----------------------------------------------------------------------------
module pcec_back #(
    parameter int NUM_CPUS      = 4,
    parameter int NUM_EVENTS    = 16,
    parameter int SYSCALL_SLOTS = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_q_valid,
    output logic                            o_q_ready,
    input  pcec_pkg::t_item                 i_q_item,
    output logic                            o_init_busy,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pcec_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcec_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pcec_pkg::AMOUNT_W-1:0]   o_result_value,
    output logic                            o_index_ok
);

    localparam int CPU_W    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
    localparam int EV_W     = $clog2(NUM_EVENTS);
    localparam int SC_W     = (SYSCALL_SLOTS > 1) ? $clog2(SYSCALL_SLOTS) : 1;
    localparam int EV_AW    = CPU_W + EV_W;
    localparam int SC_AW    = CPU_W + SC_W;
    localparam int CLR_W    = (EV_AW > SC_AW) ? EV_AW : SC_AW;
    localparam int EV_DEPTH = 1 << EV_AW;
    localparam int SC_DEPTH = 1 << SC_AW;
    localparam int AW       = pcec_pkg::AMOUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPD,
        S_SC1,
        S_SC2,
        S_QRY,
        S_CLR,
        S_RESP
    } t_state;

    // Memories: event counters and the syscall table, addressed {cpu, index}.
    logic [AW-1:0] r_ev_mem  [0:EV_DEPTH-1];
    logic [AW-1:0] r_scn_mem [0:SC_DEPTH-1];
    logic [AW-1:0] r_scc_mem [0:SC_DEPTH-1];
    logic [AW-1:0] r_ev_rd;
    logic [AW-1:0] r_scn_rd;
    logic [AW-1:0] r_scc_rd;

    t_state                         r_state;
    logic                           r_init;
    logic [CLR_W-1:0]               r_clr;
    logic [CPU_W:0]                 r_qc;
    pcec_pkg::t_item                r_item;
    logic [CPU_W-1:0]               r_cpu;
    logic [AW-1:0]                  r_acc;
    logic [AW-1:0]                  r_res;
    logic                           r_ok;
    logic                           r_out_valid;
    logic [AW-1:0]                  r_out_value;
    logic                           r_out_ok;
    logic [pcec_pkg::CFG_DATA_W-1:0] r_sei;
    logic [pcec_pkg::CFG_DATA_W-1:0] r_sci;

    logic             out_free;
    logic             pop;
    logic             pop_query;
    logic [CPU_W-1:0] pop_cpu;
    t_state           start_state;
    logic             sei_ok;
    logic             sci_ok;
    logic             bump_same;
    logic [EV_AW-1:0] ev_raddr;
    logic [SC_AW-1:0] sc_raddr;
    logic             ev_we;
    logic [EV_AW-1:0] ev_waddr;
    logic [AW-1:0]    ev_wdata;
    logic             sc_we;
    logic [SC_AW-1:0] sc_waddr;
    logic [AW-1:0]    scn_wdata;
    logic [AW-1:0]    scc_wdata;
    logic [AW-1:0]    q_data;
    logic [AW-1:0]    acc_next;

    assign o_cfg_ready    = 1'b1;
    assign o_init_busy    = r_init;
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_index_ok     = r_out_ok;

    assign out_free  = !r_out_valid || i_out_ready;
    assign o_q_ready = (r_state == S_IDLE) || ((r_state == S_RESP) && out_free);
    assign pop       = o_q_ready && i_q_valid;
    assign pop_query = (i_q_item.op == pcec_pkg::OP_EVSUM)
                    || (i_q_item.op == pcec_pkg::OP_EVMAX)
                    || (i_q_item.op == pcec_pkg::OP_SCCOUNT)
                    || (i_q_item.op == pcec_pkg::OP_SCCYCLES);
    // A CPU walk always starts at CPU 0.
    assign pop_cpu   = pop_query ? '0 : CPU_W'(i_q_item.cpu);

    assign sei_ok    = {5'b0, r_sei} < pcec_pkg::EV_CMP_W'(NUM_EVENTS);
    assign sci_ok    = {5'b0, r_sci} < pcec_pkg::EV_CMP_W'(NUM_EVENTS);
    assign bump_same = sei_ok && (r_sei == r_sci);

    always_comb begin
        unique case (i_q_item.op)
            pcec_pkg::OP_ADD,
            pcec_pkg::OP_SETMAX:  start_state = S_UPD;
            pcec_pkg::OP_SYSCALL: start_state = S_SC1;
            pcec_pkg::OP_CLEAR:   start_state = S_CLR;
            default:              start_state = S_QRY;
        endcase
    end

    // Read addresses: the first read of an item is issued as it leaves the queue.
    always_comb begin
        ev_raddr = '0;
        sc_raddr = '0;
        if (pop) begin
            if (i_q_item.op == pcec_pkg::OP_SYSCALL) begin
                ev_raddr = {pop_cpu, EV_W'(r_sei)};
            end else begin
                ev_raddr = {pop_cpu, EV_W'(i_q_item.index)};
            end
            sc_raddr = {pop_cpu, SC_W'(i_q_item.index)};
        end else if (r_state == S_SC1) begin
            ev_raddr = {r_cpu, EV_W'(r_sci)};
        end else if (r_state == S_QRY) begin
            ev_raddr = {r_qc[CPU_W-1:0], EV_W'(r_item.index)};
            sc_raddr = {r_qc[CPU_W-1:0], SC_W'(r_item.index)};
        end
    end

    // Write side of the read-modify-write steps and of the clearing sweep.
    always_comb begin
        ev_we     = 1'b0;
        ev_waddr  = '0;
        ev_wdata  = '0;
        sc_we     = 1'b0;
        sc_waddr  = '0;
        scn_wdata = '0;
        scc_wdata = '0;
        unique case (r_state)
            S_UPD: begin
                ev_we    = r_item.idx_ok;
                ev_waddr = {r_cpu, EV_W'(r_item.index)};
                if (r_item.op == pcec_pkg::OP_ADD) begin
                    ev_wdata = r_ev_rd + r_item.amount;
                end else begin
                    ev_wdata = (r_ev_rd < r_item.amount) ? r_item.amount : r_ev_rd;
                end
            end
            S_SC1: begin
                ev_we     = sei_ok;
                ev_waddr  = {r_cpu, EV_W'(r_sei)};
                ev_wdata  = r_ev_rd + AW'(1);
                sc_we     = r_item.idx_ok;
                sc_waddr  = {r_cpu, SC_W'(r_item.index)};
                scn_wdata = r_scn_rd + AW'(1);
                scc_wdata = r_scc_rd + r_item.amount;
            end
            S_SC2: begin
                // The read in S_SC1 saw the word before its increment when both
                // registers select the same counter, so the increment is added here.
                ev_we    = sci_ok;
                ev_waddr = {r_cpu, EV_W'(r_sci)};
                ev_wdata = r_ev_rd + r_item.amount + AW'(bump_same);
            end
            S_CLR: begin
                ev_we    = (r_clr >> EV_AW) == '0;
                ev_waddr = r_clr[EV_AW-1:0];
                sc_we    = (r_clr >> SC_AW) == '0;
                sc_waddr = r_clr[SC_AW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        unique case (r_item.op)
            pcec_pkg::OP_SCCOUNT:  q_data = r_scn_rd;
            pcec_pkg::OP_SCCYCLES: q_data = r_scc_rd;
            default:               q_data = r_ev_rd;
        endcase
        if (r_item.op == pcec_pkg::OP_EVMAX) begin
            acc_next = (q_data > r_acc) ? q_data : r_acc;
        end else begin
            acc_next = r_acc + q_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ev_we) begin
            r_ev_mem[ev_waddr] <= ev_wdata;
        end
        r_ev_rd <= r_ev_mem[ev_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            r_scn_mem[sc_waddr] <= scn_wdata;
            r_scc_mem[sc_waddr] <= scc_wdata;
        end
        r_scn_rd <= r_scn_mem[sc_raddr];
        r_scc_rd <= r_scc_mem[sc_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sei <= '0;
            r_sci <= pcec_pkg::CFG_DATA_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pcec_pkg::CFG_EVENT_INDEX:  r_sei <= i_cfg_data;
                pcec_pkg::CFG_CYCLES_INDEX: r_sci <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_init      <= 1'b1;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_RESP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (pop) begin
                r_item  <= i_q_item;
                r_cpu   <= pop_cpu;
                r_acc   <= '0;
                r_qc    <= (CPU_W + 1)'(1);
                r_clr   <= '0;
                r_state <= start_state;
            end
            unique case (r_state)
                S_IDLE: begin
                end
                S_UPD: begin
                    r_res   <= '0;
                    r_ok    <= r_item.idx_ok;
                    r_state <= S_RESP;
                end
                S_SC1: begin
                    r_state <= S_SC2;
                end
                S_SC2: begin
                    r_res   <= '0;
                    r_ok    <= r_item.idx_ok;
                    r_state <= S_RESP;
                end
                S_QRY: begin
                    r_acc <= acc_next;
                    if (r_qc == (CPU_W + 1)'(NUM_CPUS)) begin
                        r_res   <= r_item.idx_ok ? acc_next : '0;
                        r_ok    <= r_item.idx_ok;
                        r_state <= S_RESP;
                    end else begin
                        r_qc <= r_qc + 1'b1;
                    end
                end
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        if (r_init) begin
                            r_init  <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_res   <= '0;
                            r_ok    <= 1'b1;
                            r_state <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_value <= r_res;
                        r_out_ok    <= r_ok;
                        if (!pop) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: hdl/per_cpu_event_counter_table.sv
`timescale 1ns / 1ps
// Add and setmax: write in S_UPD, result via S_RESP, where the next item is taken.
// Syscall: two read-modify-writes on the single event memory port, in S_SC1 and S_SC2.
// Event and syscall queries: a walk over all CPUs, one CPU read per cycle.
// Clear and reset: sweep 2**max(cpu bits + event bits, cpu bits + slot bits) addresses
// (2048 at the default sizes); after reset no item is taken until the sweep ends,
// while configuration writes are accepted at any time.
// ----------------------------------------------------------------------------
// per_cpu_event_counter_table: per-CPU event counter unit
// Input stage, command queue and execution engine with the counter memories.
// ----------------------------------------------------------------------------
module per_cpu_event_counter_table #(
    parameter int NUM_CPUS      = 4,
    parameter int NUM_EVENTS    = 16,
    parameter int SYSCALL_SLOTS = 512
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [pcec_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic [pcec_pkg::CPU_ID_W-1:0]   i_cpu_id,
    input  logic [pcec_pkg::INDEX_W-1:0]    i_index,
    input  logic [pcec_pkg::AMOUNT_W-1:0]   i_amount,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [pcec_pkg::AMOUNT_W-1:0]   o_result_value,
    output logic                            o_index_ok,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pcec_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pcec_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic            init_busy;
    logic            push_valid;
    logic            push_ready;
    pcec_pkg::t_item push_item;
    logic            q_valid;
    logic            q_ready;
    pcec_pkg::t_item q_item;

    pcec_front #(
        .NUM_CPUS      (NUM_CPUS),
        .NUM_EVENTS    (NUM_EVENTS),
        .SYSCALL_SLOTS (SYSCALL_SLOTS)
    ) u_front (
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_cpu_id     (i_cpu_id),
        .i_index      (i_index),
        .i_amount     (i_amount),
        .i_init_busy  (init_busy),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    pcec_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_item   (q_item)
    );

    pcec_back #(
        .NUM_CPUS      (NUM_CPUS),
        .NUM_EVENTS    (NUM_EVENTS),
        .SYSCALL_SLOTS (SYSCALL_SLOTS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .o_q_ready      (q_ready),
        .i_q_item       (q_item),
        .o_init_busy    (init_busy),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_result_value (o_result_value),
        .o_index_ok     (o_index_ok)
    );

endmodule

// File: hdl/pcec_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcec_checker: port-level checks of the per-CPU event counter table
// Watches the top-level ports and tracks how many items are in flight.
// ----------------------------------------------------------------------------
module pcec_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [pcec_pkg::AMOUNT_W-1:0] o_result_value,
    input logic                          o_index_ok
);

    logic [3:0] r_pending;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_pending <= r_pending + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    // Every result belongs to an item that was taken in earlier.
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pending != 4'd0)
        else $error("result shown with no item in flight");

    // An ignored index never carries a nonzero answer.
    a_zero_when_not_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_index_ok) |-> o_result_value == '0)
        else $error("nonzero result with index_ok low");

    // Right after reset the clearing sweep blocks input and no result is pending.
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> (!o_in_ready && !o_out_valid))
        else $error("block active right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_result_value) && $stable(o_index_ok)))
        else $error("stalled result changed");

endmodule

bind per_cpu_event_counter_table pcec_checker u_pcec_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_value (o_result_value),
    .o_index_ok     (o_index_ok)
);
